// ===== src/lrsf_pkg.sv =====
`default_nettype none

package lrsf_pkg;

    // field widths
    localparam int DATA_W   = 32;
    localparam int PERIOD_W = 16;
    localparam int IDX_W    = 2;

    // configuration reset and default interval count
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd1000;
    localparam int NUM_INTERVALS_DEF = 3;

    // rate lanes
    localparam int NUM_RATES = 5;
    localparam int RATE_TXF  = 0;
    localparam int RATE_RXF  = 1;
    localparam int RATE_TXO  = 2;
    localparam int RATE_RXO  = 3;
    localparam int RATE_LOSS = 4;

    // filter intervals, divisors 1, 10 and 60
    localparam logic [IDX_W-1:0] IVL_1S  = 2'd0;
    localparam logic [IDX_W-1:0] IVL_10S = 2'd1;
    localparam logic [IDX_W-1:0] IVL_60S = 2'd2;

    typedef enum logic {
        OP_SAMPLE = 1'b0,
        OP_CLEAR  = 1'b1
    } opcode_t;

    // request decision from the front end
    typedef struct packed {
        logic start;
        logic clear;
    } front_evt_t;

    // sequencer control shared by all filter lanes
    typedef struct packed {
        logic             clear;
        logic             issue;
        logic [IDX_W-1:0] issue_idx;
        logic             finish;
        logic [IDX_W-1:0] finish_idx;
    } lane_ctl_t;

    // delta times 1000, modulo 2^32
    function automatic logic [DATA_W-1:0] scale_rate(input logic [DATA_W-1:0] d);
        return (d << 10) - (d << 4) - (d << 3);
    endfunction

    // magnitude pre-shift: /10 = /2 then /5, /60 = /4 then /15
    function automatic logic [DATA_W-1:0] div_operand(input logic [DATA_W:0] mag,
                                                      input logic [IDX_W-1:0] idx);
        logic [DATA_W-1:0] op;
        case (idx)
            IVL_10S: op = mag[DATA_W:1];
            IVL_60S: op = {1'b0, mag[DATA_W:2]};
            default: op = '0;
        endcase
        return op;
    endfunction

    // reciprocal of 5 and of 15
    function automatic logic [DATA_W-1:0] div_recip(input logic [IDX_W-1:0] idx);
        logic [DATA_W-1:0] m;
        case (idx)
            IVL_10S: m = 32'hCCCC_CCCD;
            IVL_60S: m = 32'h8888_8889;
            default: m = '0;
        endcase
        return m;
    endfunction

    // quotient from the reciprocal product
    function automatic logic [DATA_W-1:0] div_quotient(input logic [2*DATA_W-1:0] prod,
                                                       input logic [IDX_W-1:0] idx);
        logic [DATA_W-1:0] q;
        case (idx)
            IVL_10S: q = {2'b00, prod[2*DATA_W-1:34]};
            IVL_60S: q = {3'b000, prod[2*DATA_W-1:35]};
            default: q = '0;
        endcase
        return q;
    endfunction

endpackage

`default_nettype wire

// ===== src/lrsf_front.sv =====
`default_nettype none

module lrsf_front
    import lrsf_pkg::*;
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             opcode,
    input  logic [DATA_W-1:0]                now,
    input  logic [DATA_W-1:0]                tx_frames,
    input  logic [DATA_W-1:0]                rx_frames,
    input  logic [DATA_W-1:0]                tx_octets,
    input  logic [DATA_W-1:0]                rx_octets,
    input  logic [PERIOD_W-1:0]              update_period,
    input  logic                             seq_free,
    output front_evt_t                       evt,
    output logic [NUM_RATES-1:0][DATA_W-1:0] x_rates
);

    logic              in_valid_reg;
    opcode_t           op_reg;
    logic [DATA_W-1:0] now_reg;
    logic [DATA_W-1:0] txf_reg;
    logic [DATA_W-1:0] rxf_reg;
    logic [DATA_W-1:0] txo_reg;
    logic [DATA_W-1:0] rxo_reg;

    logic [DATA_W-1:0] last_time_reg;
    logic [DATA_W-1:0] prev_txf_reg;
    logic [DATA_W-1:0] prev_rxf_reg;
    logic [DATA_W-1:0] prev_txo_reg;
    logic [DATA_W-1:0] prev_rxo_reg;
    logic [DATA_W-1:0] prev_loss_reg;

    logic [NUM_RATES-1:0][DATA_W-1:0] x_reg;
    logic [NUM_RATES-1:0][DATA_W-1:0] x_next;

    logic              consume;
    logic              due;
    logic [DATA_W-1:0] elapsed;
    logic [DATA_W-1:0] loss_now;

    // input register, refilled as soon as its request is taken
    assign consume  = in_valid_reg && seq_free;
    assign in_ready = !in_valid_reg || consume;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
        end else if (in_ready) begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk) begin
        if (in_ready && in_valid) begin
            op_reg  <= opcode_t'(opcode);
            now_reg <= now;
            txf_reg <= tx_frames;
            rxf_reg <= rx_frames;
            txo_reg <= tx_octets;
            rxo_reg <= rx_octets;
        end
    end

    // update decision
    assign elapsed = now_reg - last_time_reg;
    assign due     = elapsed >= {{(DATA_W-PERIOD_W){1'b0}}, update_period};

    assign evt.clear = consume && (op_reg == OP_CLEAR);
    assign evt.start = consume && (op_reg == OP_SAMPLE) && due;

    // per-period deltas
    assign loss_now = txf_reg - rxf_reg;

    always_comb begin
        x_next[RATE_TXF]  = scale_rate(txf_reg - prev_txf_reg);
        x_next[RATE_RXF]  = scale_rate(rxf_reg - prev_rxf_reg);
        x_next[RATE_TXO]  = txo_reg - prev_txo_reg;
        x_next[RATE_RXO]  = rxo_reg - prev_rxo_reg;
        x_next[RATE_LOSS] = scale_rate(loss_now - prev_loss_reg);
    end

    // remembered counts; clear keeps the update time
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            last_time_reg <= '0;
            prev_txf_reg  <= '0;
            prev_rxf_reg  <= '0;
            prev_txo_reg  <= '0;
            prev_rxo_reg  <= '0;
            prev_loss_reg <= '0;
        end else if (evt.clear) begin
            prev_txf_reg  <= '0;
            prev_rxf_reg  <= '0;
            prev_txo_reg  <= '0;
            prev_rxo_reg  <= '0;
            prev_loss_reg <= '0;
        end else if (evt.start) begin
            last_time_reg <= now_reg;
            prev_txf_reg  <= txf_reg;
            prev_rxf_reg  <= rxf_reg;
            prev_txo_reg  <= txo_reg;
            prev_rxo_reg  <= rxo_reg;
            prev_loss_reg <= loss_now;
        end
    end

    // deltas held for the whole update
    always_ff @(posedge clk) begin
        if (evt.start) begin
            x_reg <= x_next;
        end
    end

    assign x_rates = x_reg;

endmodule

`default_nettype wire

// ===== src/lrsf_lane.sv =====
`default_nettype none

module lrsf_lane
    import lrsf_pkg::*;
#(
    parameter int NUM_INTERVALS = NUM_INTERVALS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  lane_ctl_t         ctl,
    input  logic [DATA_W-1:0] x,
    output logic [DATA_W-1:0] y_new
);

    logic [DATA_W-1:0] filt_reg [NUM_INTERVALS];

    logic [DATA_W-1:0]   y_cur;
    logic [DATA_W:0]     diff;
    logic [DATA_W:0]     mag;
    logic [2*DATA_W-1:0] prod;
    logic [DATA_W-1:0]   q;

    logic [2*DATA_W-1:0] prod_reg;
    logic                neg_reg;
    logic [DATA_W-1:0]   base_reg;

    // filter state of the issued interval
    always_comb begin
        y_cur = '0;
        for (int i = 0; i < NUM_INTERVALS; i++) begin
            if (ctl.issue_idx == IDX_W'(i)) begin
                y_cur = filt_reg[i];
            end
        end
    end

    // exact difference, magnitude and reciprocal product
    assign diff = {x[DATA_W-1], x} - {y_cur[DATA_W-1], y_cur};
    assign mag  = diff[DATA_W] ? (~diff + 1'b1) : diff;
    assign prod = div_operand(mag, ctl.issue_idx) * div_recip(ctl.issue_idx);

    always_ff @(posedge clk) begin
        if (ctl.issue) begin
            prod_reg <= prod;
            neg_reg  <= diff[DATA_W];
            base_reg <= (ctl.issue_idx == IVL_1S) ? x : y_cur;
        end
    end

    // quotient truncated toward zero, added back to the state; the 1s interval takes x
    assign q     = div_quotient(prod_reg, ctl.finish_idx);
    assign y_new = neg_reg ? (base_reg - q) : (base_reg + q);

    // clear wins over a write-back that lands on the same edge
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            for (int i = 0; i < NUM_INTERVALS; i++) begin
                filt_reg[i] <= '0;
            end
        end else if (ctl.clear) begin
            for (int i = 0; i < NUM_INTERVALS; i++) begin
                filt_reg[i] <= '0;
            end
        end else if (ctl.finish) begin
            for (int i = 0; i < NUM_INTERVALS; i++) begin
                if (ctl.finish_idx == IDX_W'(i)) begin
                    filt_reg[i] <= y_new;
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== src/link_rate_statistics_filter.sv =====
// Link rate statistics filter: moving-average rate estimator over link counters.
// Input channel (in_valid/in_ready): one request carries opcode, tick time now and
// the running tx/rx frame and byte counters. A sample request whose time is at
// least update_period ticks past the last update produces NUM_INTERVALS results,
// one per filter interval (divisors 1, 10, 60), the final one flagged by last.
// Clear requests and early samples produce no result.
// Output channel (out_valid/out_ready): filtered tx/rx frame rates, byte rates and
// loss rate with their interval_index. Config channel (cfg_valid/cfg_ready) writes
// update_period; cfg_ready is always high.
// The first result of an update passes the input, sequencer, issue and result
// registers; the rest follow one per cycle unless the receiver stalls, as the
// sequencer walks the intervals through the shared reciprocal multiplier of each
// lane. Requests without results are taken one per cycle while it is idle.
// A stalled receiver holds the result register, the walk and then the input side.
// Reset clears all counts and filters and sets update_period to 1000.
`default_nettype none

module link_rate_statistics_filter
    import lrsf_pkg::*;
#(
    parameter int NUM_INTERVALS = NUM_INTERVALS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [PERIOD_W-1:0]      cfg_data,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     opcode,
    input  logic [DATA_W-1:0]        now,
    input  logic [DATA_W-1:0]        tx_frames,
    input  logic [DATA_W-1:0]        rx_frames,
    input  logic [DATA_W-1:0]        tx_octets,
    input  logic [DATA_W-1:0]        rx_octets,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [IDX_W-1:0]         interval_index,
    output logic signed [DATA_W-1:0] tx_frame_avg,
    output logic signed [DATA_W-1:0] rx_frame_avg,
    output logic signed [DATA_W-1:0] tx_octet_avg,
    output logic signed [DATA_W-1:0] rx_octet_avg,
    output logic signed [DATA_W-1:0] lost_frame_avg,
    output logic                     last
);

    logic [PERIOD_W-1:0] period_reg;

    front_evt_t                       evt;
    logic [NUM_RATES-1:0][DATA_W-1:0] x_rates;
    logic [NUM_RATES-1:0][DATA_W-1:0] y_new;
    lane_ctl_t                        ctl;

    logic             busy_reg;
    logic [IDX_W-1:0] cnt_reg;
    logic             p1_valid_reg;
    logic [IDX_W-1:0] p1_idx_reg;
    logic             adv;
    logic             issue;
    logic             finish;
    logic             seq_free;

    logic                             out_valid_reg;
    logic [IDX_W-1:0]                 idx_out_reg;
    logic                             last_reg;
    logic [NUM_RATES-1:0][DATA_W-1:0] rate_reg;

    // configuration register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            period_reg <= PERIOD_RESET;
        end else if (cfg_valid) begin
            period_reg <= cfg_data;
        end
    end

    // front end: input register, update decision, deltas
    lrsf_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .opcode        (opcode),
        .now           (now),
        .tx_frames     (tx_frames),
        .rx_frames     (rx_frames),
        .tx_octets     (tx_octets),
        .rx_octets     (rx_octets),
        .update_period (period_reg),
        .seq_free      (seq_free),
        .evt           (evt),
        .x_rates       (x_rates)
    );

    // interval sequencer: issue stage then write-back into the result register
    assign adv      = !out_valid_reg || out_ready;
    assign issue    = busy_reg && adv;
    assign finish   = p1_valid_reg && adv;
    assign seq_free = !busy_reg && (!p1_valid_reg || adv);

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            busy_reg     <= 1'b0;
            cnt_reg      <= '0;
            p1_valid_reg <= 1'b0;
            p1_idx_reg   <= '0;
        end else begin
            if (evt.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (issue) begin
                if (cnt_reg == IDX_W'(NUM_INTERVALS - 1)) begin
                    busy_reg <= 1'b0;
                end
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (adv) begin
                p1_valid_reg <= issue;
                p1_idx_reg   <= cnt_reg;
            end
        end
    end

    assign ctl.clear      = evt.clear;
    assign ctl.issue      = issue;
    assign ctl.issue_idx  = cnt_reg;
    assign ctl.finish     = finish;
    assign ctl.finish_idx = p1_idx_reg;

    // one filter lane per rate
    for (genvar r = 0; r < NUM_RATES; r++) begin : g_lane
        lrsf_lane #(
            .NUM_INTERVALS (NUM_INTERVALS)
        ) u_lane (
            .clk   (clk),
            .rst_n (rst_n),
            .ctl   (ctl),
            .x     (x_rates[r]),
            .y_new (y_new[r])
        );
    end

    // result register
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= p1_valid_reg;
        end
    end

    always_ff @(posedge clk) begin
        if (finish) begin
            idx_out_reg <= p1_idx_reg;
            last_reg    <= (p1_idx_reg == IDX_W'(NUM_INTERVALS - 1));
            rate_reg    <= y_new;
        end
    end

    assign out_valid      = out_valid_reg;
    assign interval_index = idx_out_reg;
    assign last           = last_reg;
    assign tx_frame_avg   = rate_reg[RATE_TXF];
    assign rx_frame_avg   = rate_reg[RATE_RXF];
    assign tx_octet_avg   = rate_reg[RATE_TXO];
    assign rx_octet_avg   = rate_reg[RATE_RXO];
    assign lost_frame_avg = rate_reg[RATE_LOSS];

    // checks
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        evt.start |-> !busy_reg)
        else $error("update started while sequencer busy");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        evt.start |=> busy_reg)
        else $error("update start did not arm the sequencer");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (cnt_reg < IDX_W'(NUM_INTERVALS)))
        else $error("interval counter out of range");

    a_clear_safe: assert property (@(posedge clk) disable iff (!rst_n)
        evt.clear |-> (!p1_valid_reg || adv))
        else $error("clear while a filter write-back is pending");

    a_next_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !last_reg) |-> p1_valid_reg)
        else $error("non-final result without its successor in flight");

endmodule

`default_nettype wire
